### hw/rtl/bsoc_pkg.sv
// Package with the discharge curve, widths and sequencer states of the state-of-charge lookup.
package bsoc_pkg;

	localparam int MV_W       = 13;
	localparam int PCT_W      = 7;
	localparam int CURVE_LEN  = 12;
	localparam int NUM_POINTS = 12;
	localparam int PTS_USED   = (NUM_POINTS < 2) ? 2 :
		((NUM_POINTS > CURVE_LEN) ? CURVE_LEN : NUM_POINTS);
	localparam int IDX_W      = $clog2(CURVE_LEN);
	localparam int QBIT_W     = $clog2(PCT_W);
	localparam int PROD_W     = MV_W + PCT_W;
	localparam int PCT_MAX    = 100;

	typedef logic [MV_W-1:0]   mv_t;
	typedef logic [PCT_W-1:0]  pct_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [PROD_W-1:0] prod_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic mv_t curve_mv(input idx_t idx);
		mv_t mv;
		unique case (idx)
			idx_t'(0):  mv = mv_t'(4200);
			idx_t'(1):  mv = mv_t'(4100);
			idx_t'(2):  mv = mv_t'(4000);
			idx_t'(3):  mv = mv_t'(3930);
			idx_t'(4):  mv = mv_t'(3870);
			idx_t'(5):  mv = mv_t'(3800);
			idx_t'(6):  mv = mv_t'(3750);
			idx_t'(7):  mv = mv_t'(3700);
			idx_t'(8):  mv = mv_t'(3650);
			idx_t'(9):  mv = mv_t'(3550);
			idx_t'(10): mv = mv_t'(3400);
			idx_t'(11): mv = mv_t'(3000);
			default:    mv = '0;
		endcase
		return mv;
	endfunction

	function automatic pct_t curve_pct(input idx_t idx);
		pct_t pct;
		unique case (idx)
			idx_t'(0):  pct = pct_t'(100);
			idx_t'(1):  pct = pct_t'(90);
			idx_t'(2):  pct = pct_t'(80);
			idx_t'(3):  pct = pct_t'(70);
			idx_t'(4):  pct = pct_t'(60);
			idx_t'(5):  pct = pct_t'(50);
			idx_t'(6):  pct = pct_t'(40);
			idx_t'(7):  pct = pct_t'(30);
			idx_t'(8):  pct = pct_t'(20);
			idx_t'(9):  pct = pct_t'(10);
			idx_t'(10): pct = pct_t'(5);
			idx_t'(11): pct = pct_t'(0);
			default:    pct = '0;
		endcase
		return pct;
	endfunction

	// Voltage span of the segment above a breakpoint, zero when not positive.
	function automatic mv_t seg_span(input idx_t idx);
		mv_t hi;
		mv_t lo;
		hi = (idx == '0) ? '0 : curve_mv(idx - idx_t'(1));
		lo = curve_mv(idx);
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

	// Percent rise of the segment above a breakpoint, zero when negative.
	function automatic pct_t seg_rise(input idx_t idx);
		pct_t hi;
		pct_t lo;
		hi = (idx == '0) ? '0 : curve_pct(idx - idx_t'(1));
		lo = curve_pct(idx);
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

endpackage

### hw/rtl/battery_soc_interpolator.sv
// Battery state-of-charge lookup by piecewise linear interpolation over a discharge curve.
//
// Channel  Signals                     Width  Direction
// input    in_valid, in_ready          -      request in
//          millivolts                  13     unsigned millivolts
// output   out_valid, out_ready        -      request out
//          percent                     7      state of charge, 0 to 100
//
// A request scans the breakpoints with one compare per cycle; inside a segment it then
// takes a multiply step and one quotient bit per cycle, all compares and divide steps
// on one shared subtractor. in_ready is high only while the sequencer is idle; a
// finished result waits in the output register while out_ready is low, and a new
// result holds the sequencer in ST_DONE until that register is free to take it.
// Reset is asynchronous and clears the sequencer and the output valid flag.
module battery_soc_interpolator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [bsoc_pkg::MV_W-1:0]  millivolts,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [bsoc_pkg::PCT_W-1:0] percent
);

	localparam bsoc_pkg::idx_t LAST_IDX = bsoc_pkg::idx_t'(bsoc_pkg::PTS_USED - 1);

	bsoc_pkg::state_t  state_q;
	bsoc_pkg::state_t  state_d;
	bsoc_pkg::mv_t     mv_q;
	bsoc_pkg::idx_t    idx_q;
	bsoc_pkg::prod_t   rem_q;
	bsoc_pkg::pct_t    quot_q;
	bsoc_pkg::pct_t    base_q;
	logic [bsoc_pkg::QBIT_W-1:0] bit_q;
	bsoc_pkg::pct_t    percent_q;
	logic              out_valid_q;

	bsoc_pkg::prod_t   sub_a;
	bsoc_pkg::prod_t   sub_b;
	logic [bsoc_pkg::PROD_W:0] sub_y;
	logic              sub_ge;
	bsoc_pkg::mv_t     span;
	bsoc_pkg::pct_t    rise;
	logic [bsoc_pkg::PCT_W:0] sum;
	bsoc_pkg::pct_t    result;
	logic              out_free;

	assign span     = bsoc_pkg::seg_span(idx_q);
	assign rise     = bsoc_pkg::seg_rise(idx_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sub_a = rem_q;
		sub_b = bsoc_pkg::prod_t'(span) << bit_q;
		if (state_q == bsoc_pkg::ST_SCAN) begin
			sub_a = bsoc_pkg::prod_t'(mv_q);
			sub_b = bsoc_pkg::prod_t'(bsoc_pkg::curve_mv(idx_q));
		end
	end

	assign sub_y  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_y[bsoc_pkg::PROD_W];

	assign sum    = {1'b0, base_q} + {1'b0, quot_q};
	assign result = (sum > (bsoc_pkg::PCT_W + 1)'(bsoc_pkg::PCT_MAX)) ?
		bsoc_pkg::pct_t'(bsoc_pkg::PCT_MAX) : sum[bsoc_pkg::PCT_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsoc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bsoc_pkg::ST_SCAN;
				end
			end
			bsoc_pkg::ST_SCAN: begin
				if (sub_ge) begin
					state_d = (idx_q == '0) ? bsoc_pkg::ST_DONE : bsoc_pkg::ST_MUL;
				end else if (idx_q == LAST_IDX) begin
					state_d = bsoc_pkg::ST_DONE;
				end
			end
			bsoc_pkg::ST_MUL: begin
				state_d = (span == '0) ? bsoc_pkg::ST_DONE : bsoc_pkg::ST_DIV;
			end
			bsoc_pkg::ST_DIV: begin
				if (bit_q == '0) begin
					state_d = bsoc_pkg::ST_DONE;
				end
			end
			bsoc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = bsoc_pkg::ST_IDLE;
				end
			end
			default: state_d = bsoc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == bsoc_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsoc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bsoc_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bsoc_pkg::ST_IDLE: begin
				mv_q   <= millivolts;
				idx_q  <= '0;
				quot_q <= '0;
			end
			bsoc_pkg::ST_SCAN: begin
				base_q <= bsoc_pkg::curve_pct(idx_q);
				if (sub_ge) begin
					rem_q <= sub_y[bsoc_pkg::PROD_W-1:0];
				end else if (idx_q != LAST_IDX) begin
					idx_q <= idx_q + bsoc_pkg::idx_t'(1);
				end
			end
			bsoc_pkg::ST_MUL: begin
				rem_q <= bsoc_pkg::prod_t'(rem_q[bsoc_pkg::MV_W-1:0]) *
					bsoc_pkg::prod_t'(rise);
				bit_q <= (bsoc_pkg::QBIT_W)'(bsoc_pkg::PCT_W - 1);
			end
			bsoc_pkg::ST_DIV: begin
				if (sub_ge) begin
					rem_q         <= sub_y[bsoc_pkg::PROD_W-1:0];
					quot_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - (bsoc_pkg::QBIT_W)'(1);
			end
			bsoc_pkg::ST_DONE: begin
				if (out_free) begin
					percent_q <= result;
				end
			end
			default: begin
				idx_q <= '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign percent   = percent_q;

endmodule

### hw/rtl/bsoc_checker.sv
// Port-level checker for the state-of-charge lookup, with its bind to the top level.
module bsoc_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [bsoc_pkg::MV_W-1:0]  millivolts,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [bsoc_pkg::PCT_W-1:0] percent
);

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(percent))
		else $error("result changed or dropped while stalled");

	// A waiting request is not withdrawn.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(millivolts))
		else $error("request changed or dropped while stalled");

	// Results never exceed a full charge.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent <= bsoc_pkg::PCT_W'(bsoc_pkg::PCT_MAX))
		else $error("percent above full charge");

	// The block is busy in the cycle after it takes a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a request was taken");

endmodule

bind battery_soc_interpolator bsoc_checker u_bsoc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.millivolts (millivolts),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.percent    (percent)
);
